>>> hdl/qrs_pkg.sv
package qrs_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOL_BITS      = 16;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } count_e;

  // Per-equation control that rides along the pipeline
  typedef struct packed {
    count_e count;
    logic   neg1;   // sign of the single root (linear or double root)
    logic   sa;     // sign of a
    logic   sb;     // sign of b
  } ctl_t;

  localparam int CTL_BITS = $bits(ctl_t);

endpackage

>>> hdl/qrs_if.sv
interface qrs_coef_if #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  root_count;
  logic signed [WORD_BITS-1:0] root_first;
  logic signed [WORD_BITS-1:0] root_second;
  logic                        saturated;

  modport source (output valid, output root_count, output root_first, output root_second,
                  output saturated, input ready);
  modport sink   (input valid, input root_count, input root_first, input root_second,
                  input saturated, output ready);
endinterface

interface qrs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qrs_pkg::TOL_BITS-1:0]  zero_tolerance;

  modport source (output valid, output zero_tolerance, input ready);
  modport sink   (input valid, input zero_tolerance, output ready);
endinterface

>>> hdl/qrs_front.sv
module qrs_front #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [WORD_BITS-1:0]         coef_a_i,
  input  logic [WORD_BITS-1:0]         coef_b_i,
  input  logic [WORD_BITS-1:0]         coef_c_i,
  input  logic [qrs_pkg::TOL_BITS-1:0] tol_i,
  output logic                         valid_o,
  output qrs_pkg::ctl_t                ctl_o,
  output logic [WORD_BITS-1:0]         mb_o,
  output logic [WORD_BITS-1:0]         num_o,
  output logic [WORD_BITS:0]           den_o,
  output logic [2*WORD_BITS+1:0]       rad_o
);

  localparam int W  = WORD_BITS;
  localparam int L  = W / 2;
  localparam int H  = W - L;
  localparam int PW = 2 * W;
  localparam int RW = 2 * W + 2;
  localparam int CW = 3 * W + 6;

  logic [W-1:0] tol_w;
  assign tol_w = W'(tol_i);

  // Stage 1: sign/magnitude split, near-zero flags
  logic [W-1:0]  ma_d, mb_d, mc_d;
  logic [CW-1:0] c1_d, c1_q;
  logic          v1_q;

  assign ma_d = coef_a_i[W-1] ? (~coef_a_i + W'(1)) : coef_a_i;
  assign mb_d = coef_b_i[W-1] ? (~coef_b_i + W'(1)) : coef_b_i;
  assign mc_d = coef_c_i[W-1] ? (~coef_c_i + W'(1)) : coef_c_i;
  assign c1_d = {coef_a_i[W-1], coef_b_i[W-1], coef_c_i[W-1],
                 (ma_d <= tol_w), (mb_d <= tol_w), (mc_d <= tol_w), ma_d, mb_d, mc_d};

  // Stage 2: partial products of b*b and a*c
  logic [W-1:0]   ma1, mb1, mc1;
  logic [2*L-1:0] bll_q, acll_q;
  logic [L+H-1:0] blh_q, aclh_q, achl_q;
  logic [2*H-1:0] bhh_q, achh_q;
  logic [CW-1:0]  c2_q;
  logic           v2_q;

  assign ma1 = c1_q[3*W-1:2*W];
  assign mb1 = c1_q[2*W-1:W];
  assign mc1 = c1_q[W-1:0];

  // Stage 3: sum the partials
  logic [PW-1:0] p_d, p_q;
  logic [RW-1:0] q_d, q_q;
  logic [CW-1:0] c3_q;
  logic          v3_q;

  assign p_d = PW'(bll_q) + (PW'(blh_q) << (L + 1)) + (PW'(bhh_q) << (2 * L));
  assign q_d = (RW'(acll_q) + (RW'(aclh_q) << L) + (RW'(achl_q) << L)
                + (RW'(achh_q) << (2 * L))) << 2;

  // Stage 4: discriminant as sign and magnitude
  logic [RW-1:0] dmag_d, dmag_q;
  logic          dneg_d, dneg_q;
  logic [CW-1:0] c4_q;
  logic          v4_q;

  always_comb begin
    dneg_d = 1'b0;
    if (c3_q[CW-1] != c3_q[CW-3]) begin
      dmag_d = RW'(p_q) + q_q;
    end else if (RW'(p_q) >= q_q) begin
      dmag_d = RW'(p_q) - q_q;
    end else begin
      dmag_d = q_q - RW'(p_q);
      dneg_d = 1'b1;
    end
  end

  // Stage 5: classify and pick the division operands
  logic          sa4, sb4, sc4, as4, bs4, cs4;
  logic [W-1:0]  ma4, mb4, mc4;
  qrs_pkg::ctl_t ctl_d;
  logic [W-1:0]  num_d;
  logic [W:0]    den_d;
  logic [RW-1:0] rad_d;

  assign {sa4, sb4, sc4, as4, bs4, cs4, ma4, mb4, mc4} = c4_q;

  always_comb begin
    ctl_d.count = qrs_pkg::CNT_NONE;
    ctl_d.neg1  = 1'b0;
    ctl_d.sa    = sa4;
    ctl_d.sb    = sb4;
    num_d       = mb4;
    den_d       = {ma4, 1'b0};
    rad_d       = '0;
    if (as4) begin
      num_d = mc4;
      den_d = {1'b0, mb4};
      if (!bs4) begin
        ctl_d.count = qrs_pkg::CNT_ONE;
        ctl_d.neg1  = (!sc4) != sb4;
      end else if (cs4) begin
        ctl_d.count = qrs_pkg::CNT_INF;
      end
    end else if (dmag_q <= RW'(tol_i)) begin
      ctl_d.count = qrs_pkg::CNT_ONE;
      ctl_d.neg1  = (!sb4) != sa4;
    end else if (!dneg_q) begin
      ctl_d.count = qrs_pkg::CNT_TWO;
      rad_d       = dmag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= c1_d;
      bll_q  <= mb1[L-1:0] * mb1[L-1:0];
      blh_q  <= mb1[L-1:0] * mb1[W-1:L];
      bhh_q  <= mb1[W-1:L] * mb1[W-1:L];
      acll_q <= ma1[L-1:0] * mc1[L-1:0];
      aclh_q <= ma1[L-1:0] * mc1[W-1:L];
      achl_q <= ma1[W-1:L] * mc1[L-1:0];
      achh_q <= ma1[W-1:L] * mc1[W-1:L];
      c2_q   <= c1_q;
      p_q    <= p_d;
      q_q    <= q_d;
      c3_q   <= c2_q;
      dmag_q <= dmag_d;
      dneg_q <= dneg_d;
      c4_q   <= c3_q;
      ctl_o  <= ctl_d;
      mb_o   <= mb4;
      num_o  <= num_d;
      den_o  <= den_d;
      rad_o  <= rad_d;
    end
  end

endmodule

>>> hdl/qrs_isqrt.sv
module qrs_isqrt #(
  parameter int RAD_BITS  = 2 * qrs_pkg::WORD_BITS_DEF + 2,
  parameter int SIDE_BITS = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [RAD_BITS-1:0]   rad_i,
  input  logic [SIDE_BITS-1:0]  side_i,
  output logic                  valid_o,
  output logic [RAD_BITS/2-1:0] root_o,
  output logic [SIDE_BITS-1:0]  side_o
);

  localparam int SW  = RAD_BITS / 2;
  localparam int RMW = SW + 3;

  logic                 v_w    [SW+1];
  logic [RAD_BITS-1:0]  rad_w  [SW+1];
  logic [SW-1:0]        root_w [SW+1];
  logic [RMW-1:0]       rem_w  [SW+1];
  logic [SIDE_BITS-1:0] side_w [SW+1];

  assign v_w[0]    = valid_i;
  assign rad_w[0]  = rad_i;
  assign root_w[0] = '0;
  assign rem_w[0]  = '0;
  assign side_w[0] = side_i;

  // One result bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < SW; k++) begin : g_step
    logic [RMW-1:0]       rem_sh, trial, rem_nx;
    logic                 ge;
    logic                 v_q;
    logic [RAD_BITS-1:0]  rad_q;
    logic [SW-1:0]        root_q;
    logic [RMW-1:0]       rem_q;
    logic [SIDE_BITS-1:0] side_q;

    assign rem_sh = {rem_w[k][RMW-3:0], rad_w[k][RAD_BITS-1 -: 2]};
    assign trial  = RMW'({root_w[k], 2'b01});
    assign ge     = rem_sh >= trial;
    assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q  <= rad_w[k] << 2;
        root_q <= {root_w[k][SW-2:0], ge};
        rem_q  <= rem_nx;
        side_q <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_q;
    assign rad_w[k+1]  = rad_q;
    assign root_w[k+1] = root_q;
    assign rem_w[k+1]  = rem_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = v_w[SW];
  assign root_o  = root_w[SW];
  assign side_o  = side_w[SW];

endmodule

>>> hdl/qrs_div.sv
module qrs_div #(
  parameter int NUM_BITS  = 50,
  parameter int DEN_BITS  = 33,
  parameter int SIDE_BITS = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [DEN_BITS-1:0]  den_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 valid_o,
  output logic [NUM_BITS-1:0]  quo_o,
  output logic [SIDE_BITS-1:0] side_o
);

  localparam int RB = DEN_BITS + 1;

  logic                 v_w    [NUM_BITS+1];
  logic [NUM_BITS-1:0]  num_w  [NUM_BITS+1];
  logic [NUM_BITS-1:0]  quo_w  [NUM_BITS+1];
  logic [DEN_BITS-1:0]  rem_w  [NUM_BITS+1];
  logic [DEN_BITS-1:0]  den_w  [NUM_BITS+1];
  logic [SIDE_BITS-1:0] side_w [NUM_BITS+1];

  assign v_w[0]    = valid_i;
  assign num_w[0]  = num_i;
  assign quo_w[0]  = '0;
  assign rem_w[0]  = '0;
  assign den_w[0]  = den_i;
  assign side_w[0] = side_i;

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < NUM_BITS; k++) begin : g_step
    logic [RB-1:0]        rem_sh, rem_nx;
    logic                 ge;
    logic                 v_q;
    logic [NUM_BITS-1:0]  num_q, quo_q;
    logic [DEN_BITS-1:0]  rem_q, den_q;
    logic [SIDE_BITS-1:0] side_q;

    assign rem_sh = {rem_w[k], num_w[k][NUM_BITS-1]};
    assign ge     = rem_sh >= RB'(den_w[k]);
    assign rem_nx = ge ? (rem_sh - RB'(den_w[k])) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q  <= num_w[k] << 1;
        quo_q  <= {quo_w[k][NUM_BITS-2:0], ge};
        rem_q  <= rem_nx[DEN_BITS-1:0];
        den_q  <= den_w[k];
        side_q <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_q;
    assign num_w[k+1]  = num_q;
    assign quo_w[k+1]  = quo_q;
    assign rem_w[k+1]  = rem_q;
    assign den_w[k+1]  = den_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = v_w[NUM_BITS];
  assign quo_o   = quo_w[NUM_BITS];
  assign side_o  = side_w[NUM_BITS];

endmodule

>>> hdl/quadratic_root_solver_top.sv
// Channel  Role    Beat contents
// -------  ------  ----------------------------------------------------------
// coef_i   sink    coef_a, coef_b, coef_c (signed fixed point)
// root_o   source  root_count, root_first, root_second, saturated
// cfg_i    sink    zero_tolerance (16 bits, always ready)
//
// One equation per cycle enters while the output queue has room; results
// leave in order, one per cycle while root_o is ready. Results pass through
// the front stages, the square-root stages (one root bit each), the route
// register and the divider stages (one quotient bit each) to the output
// queue. Reset clears valid bits, the queue and the tolerance register.
// A stall on root_o freezes the whole pipe only once the two-entry output
// queue is full; nothing is dropped or repeated.
module quadratic_root_solver_top #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_coef_if.sink   coef_i,
  qrs_root_if.source root_o,
  qrs_cfg_if.sink    cfg_i
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int RW   = 2 * W + 2;   // radicand width
  localparam int SW   = W + 1;       // square root width
  localparam int NW   = W + 2;       // numerator magnitude width
  localparam int N    = NW + F;      // dividend / quotient width
  localparam int DB   = W + 1;       // divisor width
  localparam int SIDE = qrs_pkg::CTL_BITS + 3 * W + 1;
  localparam int EW   = 2 + 2 * W + 1;

  // Configuration: tolerance register, to be written only while the block is idle; the block does not enforce this
  logic [qrs_pkg::TOL_BITS-1:0] tol_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.zero_tolerance;
    end
  end

  // Pipeline advances whenever the output queue has room
  logic [1:0] cnt_q;
  logic       en;

  assign en           = (cnt_q != 2'd2);
  assign coef_i.ready = en;

  // Front: decode, products, discriminant, classification
  logic          fv;
  qrs_pkg::ctl_t fctl;
  logic [W-1:0]  fmb, fnum;
  logic [DB-1:0] fden;
  logic [RW-1:0] frad;

  qrs_front #(
    .WORD_BITS (W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (coef_i.valid),
    .coef_a_i (coef_i.coef_a),
    .coef_b_i (coef_i.coef_b),
    .coef_c_i (coef_i.coef_c),
    .tol_i    (tol_q),
    .valid_o  (fv),
    .ctl_o    (fctl),
    .mb_o     (fmb),
    .num_o    (fnum),
    .den_o    (fden),
    .rad_o    (frad)
  );

  // Square root of the discriminant; the rest rides alongside
  logic            sv;
  logic [SW-1:0]   sroot;
  logic [SIDE-1:0] sside;

  qrs_isqrt #(
    .RAD_BITS  (RW),
    .SIDE_BITS (SIDE)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .rad_i   (frad),
    .side_i  ({fctl, fmb, fnum, fden}),
    .valid_o (sv),
    .root_o  (sroot),
    .side_o  (sside)
  );

  // Route stage: form -b +/- sqrt(D), or the single-root numerator
  qrs_pkg::ctl_t sctl;
  logic [W-1:0]  smb, snum;
  logic [DB-1:0] sden;
  logic [NW-1:0] mb_x, s_x, mag1, mag2;
  logic          n1, n2, neg1_d, neg2_d;
  logic [N-1:0]  dvd1_d, dvd2_d;

  assign {sctl, smb, snum, sden} = sside;
  assign mb_x = NW'(smb);
  assign s_x  = NW'(sroot);

  always_comb begin
    if (sctl.sb) begin
      n1   = 1'b0;
      mag1 = mb_x + s_x;
      n2   = (mb_x < s_x);
      mag2 = n2 ? (s_x - mb_x) : (mb_x - s_x);
    end else begin
      n1   = (mb_x >= s_x);
      mag1 = n1 ? (mb_x - s_x) : (s_x - mb_x);
      n2   = 1'b1;
      mag2 = mb_x + s_x;
    end
    if (sctl.count == qrs_pkg::CNT_TWO) begin
      dvd1_d = N'(mag1) << F;
      neg1_d = n1 != sctl.sa;
    end else begin
      dvd1_d = N'(snum) << F;
      neg1_d = sctl.neg1;
    end
    dvd2_d = N'(mag2) << F;
    neg2_d = n2 != sctl.sa;
  end

  logic          rv_q;
  logic [N-1:0]  dvd1_q, dvd2_q;
  logic [DB-1:0] den_q;
  logic [1:0]    rcnt_q;
  logic          neg1_q, neg2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvd1_q <= dvd1_d;
      dvd2_q <= dvd2_d;
      den_q  <= sden;
      rcnt_q <= sctl.count;
      neg1_q <= neg1_d;
      neg2_q <= neg2_d;
    end
  end

  // Two dividers side by side, one per root
  logic         dv1, dv2;
  logic [N-1:0] quo1, quo2;
  logic [2:0]   dside1;
  logic         dneg2;

  qrs_div #(
    .NUM_BITS  (N),
    .DEN_BITS  (DB),
    .SIDE_BITS (3)
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv_q),
    .num_i   (dvd1_q),
    .den_i   (den_q),
    .side_i  ({rcnt_q, neg1_q}),
    .valid_o (dv1),
    .quo_o   (quo1),
    .side_o  (dside1)
  );

  qrs_div #(
    .NUM_BITS  (N),
    .DEN_BITS  (DB),
    .SIDE_BITS (1)
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv_q),
    .num_i   (dvd2_q),
    .den_i   (den_q),
    .side_i  (neg2_q),
    .valid_o (dv2),
    .quo_o   (quo2),
    .side_o  (dneg2)
  );

  // Apply sign and clip to the word range; returns {clipped, value}
  function automatic logic [W:0] sat_pack(input logic [N-1:0] q, input logic neg);
    logic [N-1:0] lim;
    logic [N-1:0] m;
    logic         sat;
    lim = N'(1) << (W - 1);
    if (!neg) begin
      sat = q > (lim - N'(1));
      m   = sat ? (lim - N'(1)) : q;
    end else begin
      sat = q > lim;
      m   = sat ? lim : q;
      m   = N'(0) - m;
    end
    return {sat, m[W-1:0]};
  endfunction

  qrs_pkg::count_e ocnt;
  logic [W:0]      pk1, pk2;
  logic [W-1:0]    r1, r2;
  logic            osat;

  assign ocnt = qrs_pkg::count_e'(dside1[2:1]);
  assign pk1  = sat_pack(quo1, dside1[0]);
  assign pk2  = sat_pack(quo2, dneg2);

  always_comb begin
    r1   = '0;
    r2   = '0;
    osat = 1'b0;
    case (ocnt)
      qrs_pkg::CNT_ONE: begin
        r1   = pk1[W-1:0];
        osat = pk1[W];
      end
      qrs_pkg::CNT_TWO: begin
        r1   = pk1[W-1:0];
        r2   = pk2[W-1:0];
        osat = pk1[W] | pk2[W];
      end
      default: begin
        r1 = '0;
      end
    endcase
  end

  // Two-entry output queue: decouples the pipe from root_o stalls
  logic [EW-1:0] q_mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic          push, pop;
  logic [EW-1:0] head;

  assign push = en && dv1 && dv2;
  assign pop  = root_o.valid && root_o.ready;
  assign head = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= {ocnt, r1, r2, osat};
    end
  end

  assign root_o.valid       = (cnt_q != 2'd0);
  assign root_o.root_count  = head[EW-1 -: 2];
  assign root_o.root_first  = head[2*W:W+1];
  assign root_o.root_second = head[W:1];
  assign root_o.saturated   = head[0];

`ifndef SYNTHESIS
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue overflow");

  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (root_o.valid && root_o.root_count == qrs_pkg::CNT_NONE) |->
      (root_o.root_first == '0 && root_o.root_second == '0 && !root_o.saturated))
    else $error("no-root result carries data");

  a_inf_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (root_o.valid && root_o.root_count == qrs_pkg::CNT_INF) |->
      (root_o.root_first == '0 && root_o.root_second == '0 && !root_o.saturated))
    else $error("infinite-root result carries data");

  a_one_second : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (root_o.valid && root_o.root_count == qrs_pkg::CNT_ONE) |->
      (root_o.root_second == '0))
    else $error("single-root result has a second root");

  a_div_lock : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv1 == dv2)
    else $error("divider lanes out of step");
`endif

endmodule
